// ===== hdl/trc_pkg.sv =====
// shared types, constants and the fnv-1a mixing step for the replay checker
package trc_pkg;

  localparam int unsigned TableDepthDef  = 256;
  localparam int unsigned AddressMaxDef  = 64;

  localparam logic [31:0] FnvBasis       = 32'd2166136261;
  localparam logic [31:0] FnvPrime       = 32'd16777619;
  localparam logic [3:0]  KindMax        = 4'd12;
  localparam logic [7:0]  CtrlLimit      = 8'd32;
  localparam logic [7:0]  DelChar        = 8'd127;
  localparam logic [62:0] InfMag         = 63'h7ff0_0000_0000_0000;
  localparam logic [8:0]  PosMax         = 9'd511;

  typedef enum logic [2:0] {
    OP_BLOCK_START = 3'd0,
    OP_SENDER      = 3'd1,
    OP_RECEIVER    = 3'd2,
    OP_MEMO        = 3'd3,
    OP_TX_END      = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    V_OK         = 3'd0,
    V_BAD_TOKEN  = 3'd1,
    V_NEG_AMOUNT = 3'd2,
    V_BAD_ADDR   = 3'd3,
    V_BAD_KIND   = 3'd4,
    V_REPLAY     = 3'd5,
    V_OVERFLOW   = 3'd6
  } verdict_e;

  // search request travelling down the row of table cells
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic        wr;
    logic [31:0] key;
  } probe_t;

  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [31:0] v);
    fnv_mix = 32'((h ^ v) * FnvPrime);
  endfunction

endpackage

// ===== hdl/trc_cell.sv =====
// one table cell: holds a stored hash, compares and forwards the search request
module trc_cell #(
  parameter int unsigned CntW = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  trc_pkg::probe_t probe_i,
  input  logic [CntW-1:0] remain_i,
  output trc_pkg::probe_t probe_o,
  output logic [CntW-1:0] remain_o
);

  logic            valid_q, valid_d;
  trc_pkg::probe_t probe_q, probe_d;
  logic [CntW-1:0] remain_q, remain_d;
  logic [31:0]     entry_q;
  logic            active, store;

  // entry is live while cells ahead of it still count down
  assign active = probe_i.valid && (remain_i != '0);
  assign store  = probe_i.valid && (remain_i == '0) && probe_i.wr;

  always_comb begin
    probe_d     = probe_i;
    probe_d.hit = probe_i.hit | (active && (entry_q == probe_i.key));
    probe_d.wr  = probe_i.wr & ~store;
    valid_d     = probe_i.valid;
    remain_d    = (remain_i != '0) ? remain_i - CntW'(1) : remain_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q  <= probe_d;
    remain_q <= remain_d;
    if (store) begin
      entry_q <= probe_i.key;
    end
  end

  always_comb begin
    probe_o       = probe_q;
    probe_o.valid = valid_q;
  end
  assign remain_o = remain_q;

endmodule

// ===== hdl/trc_chain.sv =====
// row of table cells forming the per-block seen-hash store
module trc_chain #(
  parameter int unsigned TableDepth = trc_pkg::TableDepthDef,
  parameter int unsigned CntW       = $clog2(TableDepth + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  trc_pkg::probe_t probe_i,
  input  logic [CntW-1:0] remain_i,
  output trc_pkg::probe_t probe_o
);

  trc_pkg::probe_t probe_w  [TableDepth+1];
  logic [CntW-1:0] remain_w [TableDepth+1];

  assign probe_w[0]  = probe_i;
  assign remain_w[0] = remain_i;

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    trc_cell #(
      .CntW(CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .probe_i (probe_w[g]),
      .remain_i(remain_w[g]),
      .probe_o (probe_w[g+1]),
      .remain_o(remain_w[g+1])
    );
  end

  assign probe_o = probe_w[TableDepth];

endmodule

// ===== hdl/transaction_replay_checker_core.sv =====
// top level of the transaction replay checker: hashing, checks and result output
// string byte requests leave busy low; a new request may follow every cycle while busy is low
// a transaction end keeps busy high through the hash tail (4 fnv mixes on the shared
// multiplier, then the check) and through the table search when it runs, in which
// the search request walks the whole row of table cells one cell per cycle
// the result strobe done_o is high in the first cycle with busy low; it cannot be stalled
// asynchronous active-low reset clears all control state; table cell entries hold no reset
module transaction_replay_checker_core #(
  parameter int unsigned TableDepth = trc_pkg::TableDepthDef,
  parameter int unsigned AddressMax = trc_pkg::AddressMaxDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        opcode_i,
  input  logic [7:0]        data_byte_i,
  input  logic signed [7:0] tok_idx_i,
  input  logic [3:0]        tx_kind_i,
  input  logic [63:0]       amount_bits_i,
  // token count register
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i,
  // result channel
  output logic              done_o,
  output logic [2:0]        verdict_o,
  output logic [31:0]       tx_hash_o,
  output logic [8:0]        tx_number_o
);

  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned LenW = $clog2(AddressMax + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_CHECK,
    ST_SEARCH
  } state_e;

  // control state
  state_e            state_q, state_d;
  logic [1:0]        step_q, step_d;
  logic [31:0]       hash_q, hash_d;
  logic [LenW-1:0]   snd_len_q, snd_len_d;
  logic [LenW-1:0]   rcv_len_q, rcv_len_d;
  logic              snd_bad_q, snd_bad_d;
  logic              rcv_bad_q, rcv_bad_d;
  logic [CntW-1:0]   seen_cnt_q, seen_cnt_d;
  trc_pkg::verdict_e blk_err_q, blk_err_d;
  logic [8:0]        pos_q, pos_d;
  logic [6:0]        tok_cnt_q, tok_cnt_d;
  logic              done_q, done_d;

  // payload captured at transaction end and result fields
  logic [7:0]        tok_q;
  logic [3:0]        kind_q;
  logic [63:0]       amount_q;
  trc_pkg::verdict_e verdict_q, verdict_d;
  logic [31:0]       out_hash_q;
  logic [8:0]        out_num_q;

  logic              accept;
  logic              is_ctrl;
  logic [31:0]       mix_word;
  logic [62:0]       mag;
  logic              amt_neg;
  logic              tok_bad;
  logic              snd_ok, rcv_ok;
  trc_pkg::verdict_e pre_verdict;
  logic              emit;

  trc_pkg::probe_t   launch, tail;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign is_ctrl = (data_byte_i < trc_pkg::CtrlLimit) || (data_byte_i == trc_pkg::DelChar);

  // words folded into the hash after the string bytes
  always_comb begin
    case (step_q)
      2'd0:    mix_word = {{24{tok_q[7]}}, tok_q};
      2'd1:    mix_word = {28'd0, kind_q};
      2'd2:    mix_word = amount_q[31:0];
      default: mix_word = amount_q[63:32];
    endcase
  end

  // minus zero and nans pass, minus infinity fails
  assign mag     = amount_q[62:0];
  assign amt_neg = amount_q[63] && (mag != '0) && !(mag > trc_pkg::InfMag);
  assign tok_bad = tok_q[7] || (tok_q >= {1'b0, tok_cnt_q});
  assign snd_ok  = (snd_len_q != '0) && (snd_len_q < LenW'(AddressMax)) && !snd_bad_q;
  assign rcv_ok  = (rcv_len_q != '0) && (rcv_len_q < LenW'(AddressMax)) && !rcv_bad_q;

  // checks in priority order; a sticky block error wins over everything
  always_comb begin
    if (blk_err_q != trc_pkg::V_OK) begin
      pre_verdict = blk_err_q;
    end else if (tok_bad) begin
      pre_verdict = trc_pkg::V_BAD_TOKEN;
    end else if (amt_neg) begin
      pre_verdict = trc_pkg::V_NEG_AMOUNT;
    end else if (!snd_ok || !rcv_ok) begin
      pre_verdict = trc_pkg::V_BAD_ADDR;
    end else if (kind_q > trc_pkg::KindMax) begin
      pre_verdict = trc_pkg::V_BAD_KIND;
    end else if (seen_cnt_q >= CntW'(TableDepth)) begin
      pre_verdict = trc_pkg::V_OVERFLOW;
    end else begin
      pre_verdict = trc_pkg::V_OK;
    end
  end

  // a clean transaction sends a search request down the table row; the slot at
  // the fill count is written on the way and only kept if no match turns up
  always_comb begin
    launch.valid = (state_q == ST_CHECK) && (pre_verdict == trc_pkg::V_OK);
    launch.hit   = 1'b0;
    launch.wr    = 1'b1;
    launch.key   = hash_q;
  end

  trc_chain #(
    .TableDepth(TableDepth),
    .CntW      (CntW)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .probe_i (launch),
    .remain_i(seen_cnt_q),
    .probe_o (tail)
  );

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    hash_d     = hash_q;
    snd_len_d  = snd_len_q;
    rcv_len_d  = rcv_len_q;
    snd_bad_d  = snd_bad_q;
    rcv_bad_d  = rcv_bad_q;
    seen_cnt_d = seen_cnt_q;
    blk_err_d  = blk_err_q;
    pos_d      = pos_q;
    tok_cnt_d  = cfg_we_i ? cfg_wdata_i : tok_cnt_q;
    done_d     = 1'b0;
    verdict_d  = verdict_q;
    emit       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            trc_pkg::OP_BLOCK_START: begin
              hash_d     = trc_pkg::FnvBasis;
              snd_len_d  = '0;
              rcv_len_d  = '0;
              snd_bad_d  = 1'b0;
              rcv_bad_d  = 1'b0;
              seen_cnt_d = '0;
              blk_err_d  = trc_pkg::V_OK;
              pos_d      = '0;
            end
            trc_pkg::OP_SENDER, trc_pkg::OP_RECEIVER, trc_pkg::OP_MEMO: begin
              // zero bytes leave hash and lengths alone
              if (data_byte_i != '0) begin
                hash_d = trc_pkg::fnv_mix(hash_q, {24'd0, data_byte_i});
                if (opcode_i == trc_pkg::OP_SENDER) begin
                  if (snd_len_q < LenW'(AddressMax)) snd_len_d = snd_len_q + LenW'(1);
                  if (is_ctrl) snd_bad_d = 1'b1;
                end else if (opcode_i == trc_pkg::OP_RECEIVER) begin
                  if (rcv_len_q < LenW'(AddressMax)) rcv_len_d = rcv_len_q + LenW'(1);
                  if (is_ctrl) rcv_bad_d = 1'b1;
                end
              end
            end
            trc_pkg::OP_TX_END: begin
              state_d = ST_MIX;
              step_d  = 2'd0;
            end
            default: begin
              // unused opcodes are dropped
            end
          endcase
        end
      end
      ST_MIX: begin
        // one multiply per cycle through the shared fnv step
        hash_d = trc_pkg::fnv_mix(hash_q, mix_word);
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (pre_verdict != trc_pkg::V_OK) begin
          verdict_d = pre_verdict;
          emit      = 1'b1;
        end else begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tail.valid) begin
          if (tail.hit) begin
            verdict_d = trc_pkg::V_REPLAY;
          end else begin
            verdict_d  = trc_pkg::V_OK;
            seen_cnt_d = seen_cnt_q + CntW'(1);
          end
          emit = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // result goes out and the transaction state starts over
    if (emit) begin
      state_d   = ST_IDLE;
      done_d    = 1'b1;
      blk_err_d = verdict_d;
      if (pos_q < trc_pkg::PosMax) pos_d = pos_q + 9'd1;
      hash_d    = trc_pkg::FnvBasis;
      snd_len_d = '0;
      rcv_len_d = '0;
      snd_bad_d = 1'b0;
      rcv_bad_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      hash_q     <= trc_pkg::FnvBasis;
      snd_len_q  <= '0;
      rcv_len_q  <= '0;
      snd_bad_q  <= 1'b0;
      rcv_bad_q  <= 1'b0;
      seen_cnt_q <= '0;
      blk_err_q  <= trc_pkg::V_OK;
      pos_q      <= '0;
      tok_cnt_q  <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      hash_q     <= hash_d;
      snd_len_q  <= snd_len_d;
      rcv_len_q  <= rcv_len_d;
      snd_bad_q  <= snd_bad_d;
      rcv_bad_q  <= rcv_bad_d;
      seen_cnt_q <= seen_cnt_d;
      blk_err_q  <= blk_err_d;
      pos_q      <= pos_d;
      tok_cnt_q  <= tok_cnt_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (opcode_i == trc_pkg::OP_TX_END)) begin
      tok_q    <= tok_idx_i;
      kind_q   <= tx_kind_i;
      amount_q <= amount_bits_i;
    end
    if (emit) begin
      verdict_q  <= verdict_d;
      out_hash_q <= hash_q;
      out_num_q  <= pos_q;
    end
  end

  assign done_o      = done_q;
  assign verdict_o   = verdict_q;
  assign tx_hash_o   = out_hash_q;
  assign tx_number_o = out_num_q;

  // a result only follows a check or the end of a table search
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == ST_CHECK || $past(state_q) == ST_SEARCH))
    else $error("result without a finished check");

  // the search request reaches the end of the row only while a search runs
  a_tail_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> (state_q == ST_SEARCH))
    else $error("stray search request at end of table row");

  // fill count never runs past the table
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_cnt_q <= CntW'(TableDepth))
    else $error("table fill count overflow");

  // a transaction end always leads into the hash tail
  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == trc_pkg::OP_TX_END)) |=> (state_q == ST_MIX && step_q == 2'd0))
    else $error("transaction end not taken into hash tail");

endmodule

// ===== verif/transaction_replay_checker_core_test.sv =====
// self-checking testbench for the transaction replay checker core
module transaction_replay_checker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 7;
  // a transaction end holds busy through the hash tail and a full walk of the table,
  // and the strobe comes in the first cycle with busy low
  localparam int QuietCycles = 5 + trc_pkg::TableDepthDef + 8;
  // longest stretch with nothing accepted: one table walk, a sender gap and
  // a full quiet period before a register write, taken several times over
  localparam int StallLimit  = 3000;
  localparam int PhaseItems  = 30;

  // opcodes outside the defined set, ignored by the block
  localparam logic [2:0] OpIgnoredLo = 3'd5;
  localparam logic [2:0] OpIgnoredHi = 3'd7;

  typedef struct {
    logic [2:0]        opcode;
    logic [7:0]        data_byte;
    logic signed [7:0] tok_idx;
    logic [3:0]        tx_kind;
    logic [63:0]       amount_bits;
  } request_t;

  typedef struct {
    trc_pkg::verdict_e v;
    logic [31:0]       hash;
    logic [8:0]        pos;
  } verdict_rec_t;

  // tracks hashing, address checks and the per-block table of seen hashes
  class replay_scoreboard;
    logic [6:0]        tok_limit;
    logic [31:0]       running_hash;
    int unsigned       sender_len;
    int unsigned       receiver_len;
    bit                sender_ctrl;
    bit                receiver_ctrl;
    logic [31:0]       block_hashes[$];
    trc_pkg::verdict_e sticky_verdict;
    int unsigned       tx_pos;
    verdict_rec_t      pending_verdicts[$];
    int unsigned       failures;

    function new();
      tok_limit = '0;
      failures = 0;
      clear_block();
    endfunction

    static function logic [31:0] fold(input logic [31:0] h, input logic [31:0] v);
      logic [31:0] x;
      x = h ^ v;
      return x * trc_pkg::FnvPrime;
    endfunction

    function void clear_tx();
      running_hash = trc_pkg::FnvBasis;
      sender_len = 0;
      receiver_len = 0;
      sender_ctrl = 1'b0;
      receiver_ctrl = 1'b0;
    endfunction

    function void clear_block();
      clear_tx();
      block_hashes.delete();
      sticky_verdict = trc_pkg::V_OK;
      tx_pos = 0;
    endfunction

    function void absorb_request(input request_t rq);
      logic [31:0]       h;
      logic [62:0]       mag;
      bit                ctrl;
      bit                neg_amount;
      trc_pkg::verdict_e v;
      ctrl = rq.data_byte < trc_pkg::CtrlLimit || rq.data_byte == trc_pkg::DelChar;
      case (rq.opcode)
        trc_pkg::OP_BLOCK_START: clear_block();
        trc_pkg::OP_SENDER, trc_pkg::OP_RECEIVER, trc_pkg::OP_MEMO: begin
          if (rq.data_byte != '0) begin
            running_hash = fold(running_hash, {24'd0, rq.data_byte});
            if (rq.opcode == trc_pkg::OP_SENDER) begin
              if (sender_len < trc_pkg::AddressMaxDef) sender_len++;
              sender_ctrl |= ctrl;
            end else if (rq.opcode == trc_pkg::OP_RECEIVER) begin
              if (receiver_len < trc_pkg::AddressMaxDef) receiver_len++;
              receiver_ctrl |= ctrl;
            end
          end
        end
        trc_pkg::OP_TX_END: begin
          h = fold(running_hash, {{24{rq.tok_idx[7]}}, rq.tok_idx});
          h = fold(h, {28'd0, rq.tx_kind});
          h = fold(h, rq.amount_bits[31:0]);
          h = fold(h, rq.amount_bits[63:32]);
          mag = rq.amount_bits[62:0];
          // minus zero and nans pass, minus infinity does not
          neg_amount = rq.amount_bits[63] && mag != '0 && !(mag > trc_pkg::InfMag);
          if (sticky_verdict != trc_pkg::V_OK) begin
            v = sticky_verdict;
          end else if (rq.tok_idx[7] || rq.tok_idx[6:0] >= tok_limit) begin
            v = trc_pkg::V_BAD_TOKEN;
          end else if (neg_amount) begin
            v = trc_pkg::V_NEG_AMOUNT;
          end else if (sender_len == 0 || sender_len >= trc_pkg::AddressMaxDef ||
                       sender_ctrl || receiver_len == 0 ||
                       receiver_len >= trc_pkg::AddressMaxDef || receiver_ctrl) begin
            v = trc_pkg::V_BAD_ADDR;
          end else if (rq.tx_kind > trc_pkg::KindMax) begin
            v = trc_pkg::V_BAD_KIND;
          end else if (block_hashes.size() >= trc_pkg::TableDepthDef) begin
            v = trc_pkg::V_OVERFLOW;
          end else begin
            v = trc_pkg::V_OK;
            foreach (block_hashes[i]) begin
              if (block_hashes[i] == h) v = trc_pkg::V_REPLAY;
            end
            if (v == trc_pkg::V_OK) block_hashes.push_back(h);
          end
          sticky_verdict = v;
          pending_verdicts.push_back('{v, h, 9'(tx_pos)});
          if (tx_pos < trc_pkg::PosMax) tx_pos++;
          clear_tx();
        end
        default: ;
      endcase
    endfunction

    function void check_result(input logic [2:0] verdict, input logic [31:0] hash,
                               input logic [8:0] pos);
      verdict_rec_t want;
      if (pending_verdicts.size() == 0) begin
        failures++;
        $display("%0t: result with none expected: verdict %0d hash %h number %0d",
                 $time, verdict, hash, pos);
        return;
      end
      want = pending_verdicts.pop_front();
      if (verdict !== want.v) begin
        failures++;
        $display("%0t: verdict expected %0d, got %0d", $time, want.v, verdict);
      end
      if (hash !== want.hash) begin
        failures++;
        $display("%0t: tx_hash expected %h, got %h", $time, want.hash, hash);
      end
      if (pos !== want.pos) begin
        failures++;
        $display("%0t: tx_number expected %0d, got %0d", $time, want.pos, pos);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        opcode_i = '0;
  logic [7:0]        data_byte_i = '0;
  logic signed [7:0] tok_idx_i = '0;
  logic [3:0]        tx_kind_i = '0;
  logic [63:0]       amount_bits_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [6:0]        cfg_wdata_i = '0;
  logic              done_o;
  logic [2:0]        verdict_o;
  logic [31:0]       tx_hash_o;
  logic [8:0]        tx_number_o;

  replay_scoreboard ledger = new();

  // requests of the transaction being sent, and of the last complete one
  request_t tx_log[$];
  request_t last_tx[$];
  int       burst_left = 0;
  int       items_sent = 0;

  transaction_replay_checker_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .data_byte_i   (data_byte_i),
    .tok_idx_i     (tok_idx_i),
    .tx_kind_i     (tx_kind_i),
    .amount_bits_i (amount_bits_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .verdict_o     (verdict_o),
    .tx_hash_o     (tx_hash_o),
    .tx_number_o   (tx_number_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // results cannot be held off, so every strobe is checked as it comes
  always @(posedge clk_i) begin
    if (rst_ni && done_o) ledger.check_result(verdict_o, tx_hash_o, tx_number_o);
  end

  // end the run if nothing moves on either side for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) idle = 0;
      else idle++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // a request with an ignored opcode and random payload everywhere
  function automatic request_t random_request();
    request_t rq;
    rq.opcode      = 3'($urandom_range(OpIgnoredLo, OpIgnoredHi));
    rq.data_byte   = 8'($urandom);
    rq.tok_idx     = 8'($urandom);
    rq.tx_kind     = 4'($urandom);
    rq.amount_bits = {$urandom, $urandom};
    return rq;
  endfunction

  // mostly printable, now and then a control byte, space or high byte
  function automatic logic [7:0] addr_byte();
    case ($urandom_range(0, 99))
      0:       return 8'($urandom_range(1, 31));
      1:       return trc_pkg::DelChar;
      2, 3:    return trc_pkg::CtrlLimit;
      4, 5, 6: return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  // address lengths: mostly short, rarely empty or just under, at or past the limit
  function automatic int addr_len();
    case ($urandom_range(0, 39))
      0:       return 0;
      1:       return $urandom_range(trc_pkg::AddressMaxDef - 1, trc_pkg::AddressMaxDef + 6);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // mostly positive amounts, plus signed zeros, infinities, nans and negatives
  function automatic logic [63:0] tx_amount();
    logic [63:0] a;
    a = {$urandom, $urandom};
    case ($urandom_range(0, 39))
      0: a = 64'h8000_0000_0000_0000;
      1: a = 64'hfff0_0000_0000_0000;
      2: a = 64'h7ff0_0000_0000_0000;
      3: a[63] = 1'b1;
      4: begin
        a[63:52] = 12'hfff;
        a[0] = 1'b1;
      end
      5: a = '1;
      6: a = 64'h8000_0000_0000_0001;
      7: a = '0;
      default: a[63] = 1'b0;
    endcase
    return a;
  endfunction

  // present one request from the falling edge and hold it until accepted;
  // the sender runs in bursts and drops start for a random gap between them
  task automatic send(input request_t rq);
    @(negedge clk_i);
    start         <= 1'b1;
    opcode_i      <= rq.opcode;
    data_byte_i   <= rq.data_byte;
    tok_idx_i     <= rq.tok_idx;
    tx_kind_i     <= rq.tx_kind;
    amount_bits_i <= rq.amount_bits;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    ledger.absorb_request(rq);
    tx_log.push_back(rq);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk_i);
      // now and then a long stretch without gaps
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
  endtask

  task automatic send_byte(input logic [2:0] op, input logic [7:0] b);
    request_t rq;
    rq = random_request();
    rq.opcode = op;
    rq.data_byte = b;
    send(rq);
  endtask

  task automatic send_close(input logic signed [7:0] tok, input logic [3:0] kind,
                            input logic [63:0] amt);
    request_t rq;
    rq = random_request();
    rq.opcode = trc_pkg::OP_TX_END;
    rq.tok_idx = tok;
    rq.tx_kind = kind;
    rq.amount_bits = amt;
    send(rq);
  endtask

  task automatic quick_tx(input logic [7:0] sb, input logic [7:0] rb,
                          input logic signed [7:0] tok, input logic [3:0] kind,
                          input logic [63:0] amt);
    send_byte(trc_pkg::OP_SENDER, sb);
    send_byte(trc_pkg::OP_RECEIVER, rb);
    send_close(tok, kind, amt);
  endtask

  // stop sending, wait for every outstanding result, then let the block settle
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (ledger.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic set_token_count(input logic [6:0] value);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    ledger.tok_limit = value;
  endtask

  // a complete transaction with random content: sender, receiver and memo
  // bytes interleaved, a sprinkle of ignored requests, then the closing request
  task automatic send_tx();
    int                ns;
    int                nr;
    int                nm;
    int                pick;
    logic signed [7:0] tok;
    logic [3:0]        kind;
    request_t          rq;
    ns = addr_len();
    nr = addr_len();
    nm = $urandom_range(0, 3);
    tx_log.delete();
    while (ns + nr + nm > 0) begin
      if ($urandom_range(0, 29) == 0) begin
        // either an undefined opcode or a zero string byte
        rq = random_request();
        if (rq.data_byte[0]) begin
          rq.opcode = 3'($urandom_range(trc_pkg::OP_SENDER, trc_pkg::OP_MEMO));
          rq.data_byte = '0;
        end
        send(rq);
      end
      pick = $urandom_range(0, ns + nr + nm - 1);
      if (pick < ns) begin
        send_byte(trc_pkg::OP_SENDER, addr_byte());
        ns--;
      end else if (pick < ns + nr) begin
        send_byte(trc_pkg::OP_RECEIVER, addr_byte());
        nr--;
      end else begin
        send_byte(trc_pkg::OP_MEMO, 8'($urandom_range(1, 255)));
        nm--;
      end
    end
    if (ledger.tok_limit != 0 && $urandom_range(0, 19) != 0)
      tok = 8'($urandom_range(0, ledger.tok_limit - 1));
    else
      tok = 8'($urandom);
    kind = ($urandom_range(0, 19) == 0) ? 4'($urandom)
                                        : 4'($urandom_range(0, trc_pkg::KindMax));
    send_close(tok, kind, tx_amount());
    last_tx = tx_log;
  endtask

  task automatic run_phase(input int count);
    int       target;
    request_t replay[$];
    target = items_sent + count;
    while (items_sent < target) begin
      case ($urandom_range(0, 49))
        0, 1, 2, 3: send_byte(trc_pkg::OP_BLOCK_START, 8'($urandom));
        // resend the last transaction byte for byte to provoke a duplicate
        4, 5, 6, 7, 8: begin
          replay = last_tx;
          foreach (replay[k]) send(replay[k]);
        end
        // transaction cut short by a block start
        9: begin
          repeat ($urandom_range(1, 4)) send_byte(trc_pkg::OP_SENDER, addr_byte());
          send_byte(trc_pkg::OP_BLOCK_START, 8'($urandom));
        end
        // sender holds off until the block has delivered everything
        10: settle();
        default: send_tx();
      endcase
    end
  endtask

  initial begin
    logic [6:0] plan [5];
    plan[0] = 7'd0;
    plan[1] = 7'd127;
    plan[2] = 7'($urandom_range(2, 63));
    plan[3] = 7'd64;
    plan[4] = 7'($urandom_range(1, 64));

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_token_count(7'd64);

    // no block start yet: the first transaction opens a block on its own;
    // zero byte and undefined opcode in the middle leave no trace
    send_byte(trc_pkg::OP_SENDER, 8'h41);
    send_byte(trc_pkg::OP_SENDER, 8'h00);
    send_byte(OpIgnoredHi, 8'($urandom));
    send_byte(trc_pkg::OP_RECEIVER, 8'hff);
    send_byte(trc_pkg::OP_MEMO, 8'h01);
    send_close(8'sd63, trc_pkg::KindMax, '0);

    // minus zero passes; the same transaction again is a replay
    send_byte(trc_pkg::OP_BLOCK_START, 8'($urandom));
    quick_tx(8'h20, 8'h7e, 8'sd0, 4'd0, 64'h8000_0000_0000_0000);
    quick_tx(8'h20, 8'h7e, 8'sd0, 4'd0, 64'h8000_0000_0000_0000);

    // delete character in the sender
    send_byte(trc_pkg::OP_BLOCK_START, 8'($urandom));
    quick_tx(trc_pkg::DelChar, 8'h62, 8'sd0, 4'd0, 64'h3ff0_0000_0000_0000);

    // token index equal to the count
    send_byte(trc_pkg::OP_BLOCK_START, 8'($urandom));
    quick_tx(8'h61, 8'h62, 8'sd64, 4'd0, '0);

    // minus infinity is negative
    send_byte(trc_pkg::OP_BLOCK_START, 8'($urandom));
    quick_tx(8'h61, 8'h62, 8'sd0, 4'd0, 64'hfff0_0000_0000_0000);

    // negative nan passes the amount check, kind 15 does not
    send_byte(trc_pkg::OP_BLOCK_START, 8'($urandom));
    quick_tx(8'h61, 8'h62, -8'sd128 + 8'sd128, 4'd15, 64'hfff8_0000_0000_0000);

    // fill the table of one block, overflow it, then push the position
    // counter into saturation with bare closing requests
    set_token_count(7'd1);
    send_byte(trc_pkg::OP_BLOCK_START, 8'($urandom));
    for (int i = 0; i < trc_pkg::TableDepthDef + 1; i++) begin
      quick_tx(8'($urandom_range(33, 126)), 8'($urandom_range(33, 126)), 8'sd0,
               4'($urandom_range(0, trc_pkg::KindMax)), {1'b0, 31'($urandom), 32'(i)});
    end
    repeat (trc_pkg::TableDepthDef) send_close(8'($urandom), 4'($urandom), tx_amount());

    // random traffic under several token counts
    for (int ph = 0; ph < 5; ph++) begin
      set_token_count(plan[ph]);
      send_byte(trc_pkg::OP_BLOCK_START, 8'($urandom));
      run_phase(PhaseItems);
    end

    settle();
    if (ledger.failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
